/* design/bhcs_pkg.sv */
// Package for the BLDC hall commutation and speed block.
// Holds the request structs, event and register codes, and the commutation table.
// No dependencies.
package bhcs_pkg;

    localparam int EdgeWidth   = 16;
    localparam int TickWidth   = 16;
    localparam int SpeedWidth  = 24;
    localparam int ScaleWidth  = 8;
    localparam int CfgWidth    = 16;

    localparam logic [EdgeWidth-1:0]  EDGE_MAX  = '1;
    localparam logic [TickWidth-1:0]  TICK_MAX  = '1;
    localparam logic [SpeedWidth-1:0] SPEED_MAX = '1;

    localparam logic [TickWidth-1:0]  WINDOW_TICKS_RESET = 16'd50;
    localparam logic [ScaleWidth-1:0] SPEED_SCALE_RESET  = 8'd50;

    typedef enum logic [1:0] {
        KIND_HALL  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_BREAK = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_WINDOW_TICKS = 1'b0,
        CFG_SPEED_SCALE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [1:0] kind;
        logic       hall_a;
        logic       hall_b;
        logic       hall_c;
    } t_in_req;

    typedef struct packed {
        logic [2:0]            high_side_enable;
        logic [2:0]            low_side_enable;
        logic [2:0]            sector;
        logic [SpeedWidth-1:0] measured_speed;
        logic                  fault;
    } t_out_req;

    typedef struct packed {
        logic [2:0] sector;
        logic [2:0] high_mask;
        logic [2:0] low_mask;
    } t_comm;

    // sector 0 marks an invalid hall pattern
    function automatic t_comm comm_lookup(input logic [2:0] pat);
        t_comm c;
        unique case (pat)
            3'b101:  c = '{sector: 3'd1, high_mask: 3'b001, low_mask: 3'b010};
            3'b100:  c = '{sector: 3'd2, high_mask: 3'b001, low_mask: 3'b100};
            3'b110:  c = '{sector: 3'd3, high_mask: 3'b010, low_mask: 3'b100};
            3'b010:  c = '{sector: 3'd4, high_mask: 3'b010, low_mask: 3'b001};
            3'b011:  c = '{sector: 3'd5, high_mask: 3'b100, low_mask: 3'b001};
            3'b001:  c = '{sector: 3'd6, high_mask: 3'b100, low_mask: 3'b010};
            default: c = '{sector: 3'd0, high_mask: 3'b000, low_mask: 3'b000};
        endcase
        return c;
    endfunction

endpackage

/* design/bldc_hall_commutation_speed.sv */
// Top level: six-step hall commutation, sticky fault break, windowed speed measurement.
// Depends on bhcs_pkg for request structs, codes and the commutation table.
//
//   channel   signals                                  direction
//   in        i_in_valid / o_in_ready / i_in           event request in
//   out       o_out_valid / i_out_ready / o_out        state request out
//   cfg       i_cfg_wr_en / i_cfg_index / i_cfg_data   register write in
//
// One request per cycle while the output is not stalled; the path has an input register and a result register.
// State updates and the 16x8 speed product happen between the two registers.
// A stalled result holds in the result register while one more request waits in
// the input register. Synchronous active-low reset; no clearing pass.
module bldc_hall_commutation_speed
    import bhcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_req            o_out,
    input  logic                i_cfg_wr_en,
    input  t_cfg_index          i_cfg_index,
    input  logic [CfgWidth-1:0] i_cfg_data
);

    logic                  r_in_valid;
    t_in_req               r_in;
    logic                  r_out_valid;
    t_out_req              r_out;

    logic [TickWidth-1:0]  r_window_ticks;
    logic [ScaleWidth-1:0] r_speed_scale;

    logic [2:0]            r_sector, n_sector;
    logic [2:0]            r_high_mask, n_high_mask;
    logic [2:0]            r_low_mask, n_low_mask;
    logic [EdgeWidth-1:0]  r_edge_count, n_edge_count;
    logic [TickWidth-1:0]  r_tick_count, n_tick_count;
    logic [SpeedWidth-1:0] r_speed, n_speed;
    logic                  r_fault, n_fault;

    logic                  out_free;
    logic                  advance;
    t_comm                 comm;
    logic [TickWidth-1:0]  tick_inc;
    logic [SpeedWidth-1:0] product;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign comm     = comm_lookup({r_in.hall_a, r_in.hall_b, r_in.hall_c});
    assign tick_inc = (r_tick_count != TICK_MAX) ? r_tick_count + 1'b1 : r_tick_count;
    assign product  = SpeedWidth'(r_edge_count) * SpeedWidth'(r_speed_scale);

    always_comb begin
        n_sector     = r_sector;
        n_high_mask  = r_high_mask;
        n_low_mask   = r_low_mask;
        n_edge_count = r_edge_count;
        n_tick_count = r_tick_count;
        n_speed      = r_speed;
        n_fault      = r_fault;
        case (r_in.kind)
            KIND_HALL: begin
                if (r_edge_count != EDGE_MAX) begin
                    n_edge_count = r_edge_count + 1'b1;
                end
                if (comm.sector != 3'd0) begin
                    n_sector    = comm.sector;
                    n_high_mask = comm.high_mask;
                    n_low_mask  = comm.low_mask;
                end
            end
            KIND_TICK: begin
                n_tick_count = tick_inc;
                if (tick_inc >= r_window_ticks) begin
                    n_speed      = (product > SPEED_MAX) ? SPEED_MAX : product;
                    n_edge_count = '0;
                    n_tick_count = '0;
                end
            end
            KIND_BREAK: begin
                n_fault = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RESET;
            r_speed_scale  <= SPEED_SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data[TickWidth-1:0];
                CFG_SPEED_SCALE:  r_speed_scale  <= i_cfg_data[ScaleWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_sector     <= '0;
            r_high_mask  <= '0;
            r_low_mask   <= '0;
            r_edge_count <= '0;
            r_tick_count <= '0;
            r_speed      <= '0;
            r_fault      <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_sector     <= n_sector;
                r_high_mask  <= n_high_mask;
                r_low_mask   <= n_low_mask;
                r_edge_count <= n_edge_count;
                r_tick_count <= n_tick_count;
                r_speed      <= n_speed;
                r_fault      <= n_fault;
            end
        end
    end

    // force switches off while faulted
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.high_side_enable <= n_fault ? 3'b000 : n_high_mask;
            r_out.low_side_enable  <= n_fault ? 3'b000 : n_low_mask;
            r_out.sector           <= n_sector;
            r_out.measured_speed   <= n_speed;
            r_out.fault            <= n_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
